// ===== hw/rtl/mrhm_pkg.sv =====
// Shared types, codes and the CRC-16 step for the Modbus read-holding master.
// Used by the configuration, controller, datapath, top-level and checker files.
`default_nettype none

package mrhm_pkg;

	// Frame constants of function 03.
	localparam logic [7:0]  FUNC_READ = 8'h03;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam int          REQ_LEN   = 8;
	localparam int          HDR_LEN   = 3;
	localparam int          CRC_LEN   = 2;

	// Configuration port.
	localparam int   APB_AW            = 3;
	localparam logic REG_SLAVE_ADDRESS = 1'b0;

	// Input item kinds.
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// Result item kinds.
	localparam logic [1:0] OUT_REQ    = 2'd0;
	localparam logic [1:0] OUT_VALUE  = 2'd1;
	localparam logic [1:0] OUT_STATUS = 2'd2;

	// Status codes.
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_BAD_ARG = 2'd1;
	localparam logic [1:0] STS_TIMEOUT = 2'd2;
	localparam logic [1:0] STS_ERROR   = 2'd3;

	// Source of the next result loaded into the output register.
	typedef enum logic [1:0] {
		SRC_REQ,
		SRC_VALUE,
		SRC_STATUS
	} out_src_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		logic       req_init;
		logic       req_emit;
		logic [2:0] req_idx;
		logic       rx_init;
		logic       rx_step;
		logic       rd_issue;
		logic [5:0] val_idx;
		logic       out_load;
		out_src_t   out_src;
		logic [1:0] out_status;
		logic       out_last;
	} mrhm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] kind;
		logic       args_bad;
		logic       rx_final;
		logic       frame_ok;
		logic [6:0] count;
	} mrhm_sts_t;

	// One byte through the reflected CRC-16, one bit per step.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/modbus_read_holding_master.sv =====
// Top level of the Modbus RTU read-holding-registers master.
// Depends on mrhm_pkg, mrhm_cfg, mrhm_ctrl and mrhm_dp.
//
//   Channel   Signals                                    Transfer when
//   -------   ----------------------------------------   -------------------------
//   in        in_valid, in_stall, kind, first_register,   in_valid && !in_stall
//             quantity, rx_byte
//   out       out_valid, out_stall, out_kind, tx_byte,    out_valid && !out_stall
//             reg_index, reg_value, status, last
//   cfg       psel, penable, pwrite, paddr, pwdata,       psel && penable && pwrite
//             prdata, pready
//
// An item is latched in the input register and then decoded by the controller. A valid
// start sends the eight request bytes one at a time; a final response byte that passes
// the frame checks has each value read from the value store through its single
// registered port before it is sent.
// Reset leaves the block idle with slave address 1; no clearing pass is needed.
// A stalled output holds the controller until the output register drains.
`default_nettype none

module modbus_read_holding_master
	import mrhm_pkg::*;
#(
	parameter int MAX_REGISTERS   = 32,
	parameter int MAX_FRAME_BYTES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        kind,
	input  wire logic [15:0]       first_register,
	input  wire logic [15:0]       quantity,
	input  wire logic [7:0]        rx_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [1:0]        out_kind,
	output logic      [7:0]        tx_byte,
	output logic      [5:0]        reg_index,
	output logic      [15:0]       reg_value,
	output logic      [1:0]        status,
	output logic                   last,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	logic [7:0] slave_address;
	mrhm_cmd_t  cmd;
	mrhm_sts_t  sts;

	// Configuration registers.
	mrhm_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.slave_address (slave_address)
	);

	// Exchange sequencer.
	mrhm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Frame building, checking and value storage.
	mrhm_dp #(
		.MAX_REGISTERS   (MAX_REGISTERS),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.slave_address  (slave_address),
		.kind           (kind),
		.first_register (first_register),
		.quantity       (quantity),
		.rx_byte        (rx_byte),
		.out_kind       (out_kind),
		.tx_byte        (tx_byte),
		.reg_index      (reg_index),
		.reg_value      (reg_value),
		.status         (status),
		.last           (last)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/mrhm_cfg.sv =====
// APB-style register file holding the slave address.
// Depends on mrhm_pkg for the address width and register index.
`default_nettype none

module mrhm_cfg
	import mrhm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output logic      [7:0]        slave_address
);

	logic       hit;
	logic [7:0] slave_q;

	// The only register sits at index zero; other addresses read as zero.
	assign hit = (paddr[APB_AW-1:2] == REG_SLAVE_ADDRESS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= 8'd1;
		end else if (psel && penable && pwrite && hit) begin
			slave_q <= pwdata[7:0];
		end
	end

	assign prdata        = hit ? {24'd0, slave_q} : 32'd0;
	assign pready        = 1'b1;
	assign slave_address = slave_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mrhm_ctrl.sv =====
// Controller state machine: sequences request bytes, response checks and value readout.
// Depends on mrhm_pkg for the command and status structs and the codes.
`default_nettype none

module mrhm_ctrl
	import mrhm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire mrhm_sts_t sts,
	output mrhm_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_READY,
		ST_EXEC,
		ST_REQ,
		ST_VREAD,
		ST_VEMIT
	} state_t;

	state_t     state_q;
	logic       awaiting_q;
	logic [2:0] req_idx_q;
	logic [5:0] val_idx_q;
	logic       out_valid_q;
	logic       out_free;
	logic       val_last;

	// The output register may take a new result when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign val_last = ({1'b0, val_idx_q} == (sts.count - 7'd1));
	assign in_stall = (state_q != ST_READY);
	assign out_valid = out_valid_q;

	// Commands for the datapath in the current cycle.
	always_comb begin
		cmd            = '0;
		cmd.out_src    = SRC_STATUS;
		cmd.req_idx    = req_idx_q;
		cmd.val_idx    = val_idx_q;
		unique case (state_q)
			ST_READY: begin
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				if (out_free) begin
					if (sts.kind == KIND_START) begin
						if (sts.args_bad) begin
							cmd.out_load   = 1'b1;
							cmd.out_status = STS_BAD_ARG;
							cmd.out_last   = 1'b1;
						end else begin
							cmd.req_init = 1'b1;
						end
					end else if (sts.kind == KIND_BYTE && awaiting_q) begin
						cmd.rx_step = 1'b1;
						if (sts.rx_final && !sts.frame_ok) begin
							cmd.out_load   = 1'b1;
							cmd.out_status = STS_ERROR;
							cmd.out_last   = 1'b1;
						end
					end else if (sts.kind == KIND_END && awaiting_q) begin
						cmd.out_load   = 1'b1;
						cmd.out_status = STS_TIMEOUT;
						cmd.out_last   = 1'b1;
					end
				end
			end
			ST_REQ: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = SRC_REQ;
					cmd.req_emit = 1'b1;
					cmd.out_last = (req_idx_q == 3'(REQ_LEN - 1));
					cmd.rx_init  = (req_idx_q == 3'(REQ_LEN - 1));
				end
			end
			ST_VREAD: begin
				cmd.rd_issue = 1'b1;
			end
			ST_VEMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = SRC_VALUE;
					cmd.out_last = val_last;
				end
			end
			default: begin
				cmd.capture = 1'b0;
			end
		endcase
	end

	// State, counters and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_READY;
			awaiting_q  <= 1'b0;
			req_idx_q   <= '0;
			val_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_READY: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						if (sts.kind == KIND_START) begin
							awaiting_q <= 1'b0;
							if (!sts.args_bad) begin
								req_idx_q <= '0;
								state_q   <= ST_REQ;
							end else begin
								state_q <= ST_READY;
							end
						end else if (sts.kind == KIND_BYTE && awaiting_q) begin
							if (sts.rx_final) begin
								awaiting_q <= 1'b0;
								if (sts.frame_ok) begin
									val_idx_q <= '0;
									state_q   <= ST_VREAD;
								end else begin
									state_q <= ST_READY;
								end
							end else begin
								state_q <= ST_READY;
							end
						end else if (sts.kind == KIND_END && awaiting_q) begin
							awaiting_q <= 1'b0;
							state_q    <= ST_READY;
						end else begin
							state_q <= ST_READY;
						end
					end
				end
				ST_REQ: begin
					if (out_free) begin
						req_idx_q <= req_idx_q + 3'd1;
						if (req_idx_q == 3'(REQ_LEN - 1)) begin
							awaiting_q <= 1'b1;
							state_q    <= ST_READY;
						end
					end
				end
				ST_VREAD: begin
					state_q <= ST_VEMIT;
				end
				ST_VEMIT: begin
					if (out_free) begin
						if (val_last) begin
							state_q <= ST_READY;
						end else begin
							val_idx_q <= val_idx_q + 6'd1;
							state_q   <= ST_VREAD;
						end
					end
				end
				default: begin
					state_q <= ST_READY;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mrhm_dp.sv =====
// Datapath: input latch, request builder, response checker, value memory, output register.
// Depends on mrhm_pkg for the structs, codes and the CRC-16 step.
`default_nettype none

module mrhm_dp
	import mrhm_pkg::*;
#(
	parameter int MAX_REGISTERS   = 32,
	parameter int MAX_FRAME_BYTES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mrhm_cmd_t   cmd,
	output mrhm_sts_t        sts,
	input  wire logic [7:0]  slave_address,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] first_register,
	input  wire logic [15:0] quantity,
	input  wire logic [7:0]  rx_byte,
	output logic      [1:0]  out_kind,
	output logic      [7:0]  tx_byte,
	output logic      [5:0]  reg_index,
	output logic      [15:0] reg_value,
	output logic      [1:0]  status,
	output logic             last
);

	localparam int AW        = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
	localparam int FRAME_QTY = (MAX_FRAME_BYTES - HDR_LEN - CRC_LEN) / 2;
	localparam int QTY_LIMIT = (MAX_REGISTERS < FRAME_QTY) ? MAX_REGISTERS : FRAME_QTY;

	// Latched input item.
	logic [1:0]  kind_q;
	logic [15:0] first_q;
	logic [15:0] qty_q;
	logic [7:0]  rxb_q;

	// Request and response state.
	logic [15:0] tx_crc_q;
	logic [15:0] rx_crc_q;
	logic [7:0]  bytes_seen_q;
	logic [6:0]  awaited_q;
	logic        frame_bad_q;
	logic [7:0]  crc_low_q;
	logic [7:0]  high_q;
	logic [15:0] rdata_q;

	// Output register payload.
	logic [1:0]  out_kind_q;
	logic [7:0]  tx_byte_q;
	logic [5:0]  reg_index_q;
	logic [15:0] reg_value_q;
	logic [1:0]  status_q;
	logic        last_q;

	logic [15:0] value_mem [MAX_REGISTERS];

	logic [7:0]  req_byte;
	logic [7:0]  body_len;
	logic        in_body;
	logic [7:0]  data_pos;
	logic [6:0]  slot;
	logic        mem_we;

	// Request byte for the current position in transmit order.
	always_comb begin
		unique case (cmd.req_idx)
			3'd0:    req_byte = slave_address;
			3'd1:    req_byte = FUNC_READ;
			3'd2:    req_byte = first_q[15:8];
			3'd3:    req_byte = first_q[7:0];
			3'd4:    req_byte = qty_q[15:8];
			3'd5:    req_byte = qty_q[7:0];
			3'd6:    req_byte = tx_crc_q[7:0];
			default: req_byte = tx_crc_q[15:8];
		endcase
	end

	// Position of the current response byte within the frame.
	assign body_len = 8'(HDR_LEN) + {awaited_q, 1'b0};
	assign in_body  = (bytes_seen_q < body_len);
	assign data_pos = bytes_seen_q - 8'(HDR_LEN);
	assign slot     = data_pos[7:1];
	assign mem_we   = cmd.rx_step && in_body && (bytes_seen_q >= 8'(HDR_LEN)) && data_pos[0];

	assign sts.kind     = kind_q;
	assign sts.args_bad = (slave_address == 8'd0) || (qty_q == 16'd0) ||
	                      (qty_q > 16'(QTY_LIMIT));
	assign sts.rx_final = (bytes_seen_q == body_len + 8'd1);
	assign sts.frame_ok = !frame_bad_q && ({rxb_q, crc_low_q} == rx_crc_q);
	assign sts.count    = awaited_q;

	// CRC accumulators and frame checks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_crc_q     <= CRC_INIT;
			rx_crc_q     <= CRC_INIT;
			bytes_seen_q <= '0;
			awaited_q    <= '0;
			frame_bad_q  <= 1'b0;
			crc_low_q    <= '0;
			high_q       <= '0;
		end else begin
			if (cmd.req_init) begin
				tx_crc_q <= CRC_INIT;
			end else if (cmd.req_emit && (cmd.req_idx < 3'(REQ_LEN - CRC_LEN))) begin
				tx_crc_q <= crc_feed(tx_crc_q, req_byte);
			end
			if (cmd.rx_init) begin
				rx_crc_q     <= CRC_INIT;
				bytes_seen_q <= '0;
				awaited_q    <= qty_q[6:0];
				frame_bad_q  <= 1'b0;
				crc_low_q    <= '0;
				high_q       <= '0;
			end else if (cmd.rx_step) begin
				bytes_seen_q <= bytes_seen_q + 8'd1;
				if (in_body) begin
					rx_crc_q <= crc_feed(rx_crc_q, rxb_q);
					if (bytes_seen_q == 8'd0) begin
						if (rxb_q != slave_address) frame_bad_q <= 1'b1;
					end else if (bytes_seen_q == 8'd1) begin
						if (rxb_q != FUNC_READ) frame_bad_q <= 1'b1;
					end else if (bytes_seen_q == 8'd2) begin
						if (rxb_q != {awaited_q, 1'b0}) frame_bad_q <= 1'b1;
					end else if (!data_pos[0]) begin
						high_q <= rxb_q;
					end
				end else if (bytes_seen_q == body_len) begin
					crc_low_q <= rxb_q;
				end
			end
		end
	end

	// Input latch and output payload; these need no reset.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			first_q <= first_register;
			qty_q   <= quantity;
			rxb_q   <= rx_byte;
		end
		if (cmd.out_load) begin
			last_q <= cmd.out_last;
			unique case (cmd.out_src)
				SRC_REQ: begin
					out_kind_q  <= OUT_REQ;
					tx_byte_q   <= req_byte;
					reg_index_q <= '0;
					reg_value_q <= '0;
					status_q    <= STS_OK;
				end
				SRC_VALUE: begin
					out_kind_q  <= OUT_VALUE;
					tx_byte_q   <= '0;
					reg_index_q <= cmd.val_idx;
					reg_value_q <= rdata_q;
					status_q    <= STS_OK;
				end
				default: begin
					out_kind_q  <= OUT_STATUS;
					tx_byte_q   <= '0;
					reg_index_q <= '0;
					reg_value_q <= '0;
					status_q    <= cmd.out_status;
				end
			endcase
		end
	end

	// Register value store with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			value_mem[slot[AW-1:0]] <= {high_q, rxb_q};
		end
		if (cmd.rd_issue) begin
			rdata_q <= value_mem[cmd.val_idx[AW-1:0]];
		end
	end

	assign out_kind  = out_kind_q;
	assign tx_byte   = tx_byte_q;
	assign reg_index = reg_index_q;
	assign reg_value = reg_value_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mrhm_checker.sv =====
// Port-level checks of the read-holding master, attached to the top level by bind.
// Depends on mrhm_pkg for the result kinds and status codes.
`default_nettype none

module mrhm_checker
	import mrhm_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [1:0]        out_kind,
	input wire logic [7:0]        tx_byte,
	input wire logic [5:0]        reg_index,
	input wire logic [15:0]       reg_value,
	input wire logic [1:0]        status,
	input wire logic              last
);

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(tx_byte) &&
		$stable(reg_index) && $stable(reg_value) && $stable(status) && $stable(last))
	else $error("stalled result changed");

	// Every accepted item is decoded before the next transfer is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
	else $error("input taken while an item is being decoded");

	// A status result always closes the results of its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == OUT_STATUS) |-> last)
	else $error("status result without last");

	// Request bytes and register values carry an ok status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind != OUT_STATUS) |-> (status == STS_OK))
	else $error("non-status result with an error status");

endmodule

bind modbus_read_holding_master mrhm_checker u_mrhm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_kind  (out_kind),
	.tx_byte   (tx_byte),
	.reg_index (reg_index),
	.reg_value (reg_value),
	.status    (status),
	.last      (last)
);

`default_nettype wire
